// File: hdl/shpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_pkg
// Shared types and constants for the sync header packet deframer.
// ---------------------------------------------------------------------------
package shpd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER_PATTERN   = 2'd0;
    localparam logic [1:0] REG_MAX_FRAME_LENGTH = 2'd1;
    localparam logic [1:0] REG_ENDPOINT_COUNT   = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // reset values of the registers
    localparam logic [31:0] RST_HEADER_PATTERN   = 32'h0FAA_55F0;
    localparam logic [15:0] RST_MAX_FRAME_LENGTH = 16'd1024;
    localparam logic [15:0] RST_ENDPOINT_COUNT   = 16'd16;

    // length field counts the two endpoint bytes as well
    localparam logic [15:0] EP_FIELD_BYTES = 16'd2;

    // result queue depth default
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        EV_DATA    = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_LEN_REJ = 2'd2,
        EV_EP_REJ  = 2'd3
    } t_event_kind;

    typedef struct packed {
        logic [31:0] header_pattern;
        logic [15:0] max_frame_length;
        logic [15:0] endpoint_count;
    } t_cfg;

    typedef struct packed {
        t_event_kind event_kind;
        logic [15:0] endpoint;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        last;
    } t_result;

endpackage

// File: hdl/shpd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_front
// Byte parser: header hunt, length and endpoint fields, payload indexing.
// ---------------------------------------------------------------------------
module shpd_front
    import shpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_EP   = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_step,  n_step;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_ep,    n_ep;

    logic [7:0]  expect_byte;
    logic [15:0] field_full;
    logic [15:0] len_full_ep;
    logic        fin;

    assign expect_byte = 8'(i_cfg.header_pattern >> {r_step[1:0], 3'b000});
    // little-endian field: high byte arrives second
    assign field_full  = {i_rx_byte, r_len[7:0]};
    assign len_full_ep = {i_rx_byte, r_ep[7:0]};
    assign fin = ({1'b0, r_step} + 17'd1) >= {1'b0, r_len};

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_len       = r_len;
        n_ep        = r_ep;
        o_res_valid = 1'b0;
        o_res       = '{event_kind: EV_DATA, endpoint: 16'd0, data_byte: 8'd0,
                        byte_index: 16'd0, last: 1'b1};
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == expect_byte) begin
                        if (r_step[1:0] == 2'd3) begin
                            n_phase = PH_LEN;
                            n_step  = 16'd0;
                        end else begin
                            n_step = r_step + 16'd1;
                        end
                    end else begin
                        // mismatching byte is not retried as a first header byte
                        n_step = 16'd0;
                    end
                end
                PH_LEN: begin
                    if (!r_step[0]) begin
                        n_len  = {8'd0, i_rx_byte};
                        n_step = 16'd1;
                    end else if (field_full > i_cfg.max_frame_length ||
                                 field_full < EP_FIELD_BYTES) begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_LEN_REJ;
                        n_phase          = PH_HUNT;
                        n_step           = 16'd0;
                    end else begin
                        n_len   = field_full - EP_FIELD_BYTES;
                        n_phase = PH_EP;
                        n_step  = 16'd0;
                    end
                end
                PH_EP: begin
                    if (!r_step[0]) begin
                        n_ep   = {8'd0, i_rx_byte};
                        n_step = 16'd1;
                    end else if (len_full_ep >= i_cfg.endpoint_count) begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_EP_REJ;
                        o_res.endpoint   = len_full_ep;
                        n_phase          = PH_HUNT;
                        n_step           = 16'd0;
                    end else if (r_len == 16'd0) begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_EMPTY;
                        o_res.endpoint   = len_full_ep;
                        n_phase          = PH_HUNT;
                        n_step           = 16'd0;
                    end else begin
                        n_ep    = len_full_ep;
                        n_phase = PH_DATA;
                        n_step  = 16'd0;
                    end
                end
                PH_DATA: begin
                    o_res_valid      = 1'b1;
                    o_res.event_kind = EV_DATA;
                    o_res.endpoint   = r_ep;
                    o_res.data_byte  = i_rx_byte;
                    o_res.byte_index = r_step;
                    o_res.last       = fin;
                    if (fin) begin
                        n_phase = PH_HUNT;
                        n_step  = 16'd0;
                    end else begin
                        n_step = r_step + 16'd1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_step  = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_step  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_ep  <= n_ep;
    end

    // field bytes counted with one bit only
    a_field_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN || r_phase == PH_EP) |-> r_step < 16'd2)
        else $error("field step count out of range");

    // payload index stays below the payload length
    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> r_step < r_len)
        else $error("payload index overran length");

endmodule

// File: hdl/shpd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_queue
// Result queue between parser and output port.
// ---------------------------------------------------------------------------
module shpd_queue
    import shpd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_wdata,
    input  logic    i_pop,
    output t_result o_rdata,
    output logic    o_full,
    output logic    o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // parser must never offer a result the queue cannot take
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result dropped on full queue");

    // occupancy agrees with the pointers: they meet when the queue is empty or full
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

// File: hdl/sync_header_packet_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_header_packet_deframer
// Sync header hunt, length/endpoint parse and payload byte tagging.
// ---------------------------------------------------------------------------
// Usage
//  - Input channel: one received byte per transaction on i_rx_byte, taken at
//    a clock edge with push high and full low.
//  - Result channel: oldest result on o_event_kind/o_endpoint/o_data_byte/
//    o_byte_index/o_last while empty is low; taken when pop is high.
//  - Config: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
//    (0 header pattern, 1 max frame length, 2 endpoint count). Write only
//    while the block is idle; index 3 is ignored.
//  - Throughput: one byte per cycle while full is low; each byte is parsed combinationally.
//  - Latency: a result enters the queue at the edge its byte is taken and is
//    visible (empty low) in the following cycle.
//  - Stall: results gather in a DEPTH-entry queue (QUEUE_DEPTH by default);
//    full rises only when the queue is full, so the receiver may stall that
//    many results before the byte stream is held off.
//  - Reset: parser returns to the header hunt, queue empties, registers
//    take their default values.
// ---------------------------------------------------------------------------
module sync_header_packet_deframer
    import shpd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte input
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_rx_byte,
    // results
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_event_kind,
    output logic [15:0]            o_endpoint,
    output logic [7:0]             o_data_byte,
    output logic [15:0]            o_byte_index,
    output logic                   o_last,
    // configuration
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result q_head;

    // register file; writes to the unused index fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_pattern   <= RST_HEADER_PATTERN;
            r_cfg.max_frame_length <= RST_MAX_FRAME_LENGTH;
            r_cfg.endpoint_count   <= RST_ENDPOINT_COUNT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_HEADER_PATTERN:   r_cfg.header_pattern   <= i_cfg_wdata;
                REG_MAX_FRAME_LENGTH: r_cfg.max_frame_length <= i_cfg_wdata[15:0];
                REG_ENDPOINT_COUNT:   r_cfg.endpoint_count   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // a byte may yield one result, so hold off whenever the queue is full
    assign accept = push && !full;

    shpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    shpd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata (res),
        .i_pop   (pop),
        .o_rdata (q_head),
        .o_full  (full),
        .o_empty (empty)
    );

    assign o_event_kind = q_head.event_kind;
    assign o_endpoint   = q_head.endpoint;
    assign o_data_byte  = q_head.data_byte;
    assign o_byte_index = q_head.byte_index;
    assign o_last       = q_head.last;

endmodule
